@@ sv/cbcc_pkg.sv @@
// cbcc_pkg: shared constants, register codes and control structs
// for the color blob column centroid block; no dependencies

package cbcc_pkg;

    // frame geometry
    localparam int FRAME_COLUMNS = 512;
    localparam int HALF_COLUMNS  = FRAME_COLUMNS / 2;
    localparam int COL_W         = $clog2(FRAME_COLUMNS);
    localparam int REL_W         = COL_W + 1;

    // field widths
    localparam int HUE_W = 8;
    localparam int SAT_W = 8;
    localparam int AVG_W = 9;
    localparam int CFG_W = 8;

    // accumulator widths
    localparam int CNT_W = 19;
    localparam int SUM_W = 28;

    // divider sequencing: one quotient bit per cycle
    localparam int DIV_STEPS = SUM_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // saturation limits of the reported average
    localparam int AVG_MAX     = 255;
    localparam int AVG_MIN_MAG = 256;

    // saturation window ceiling
    localparam logic [SAT_W-1:0] SAT_MAX = 8'hFF;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_HUE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_SAT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAT_TOL     = 2'd2;

    // configuration reset values
    localparam logic [CFG_W-1:0] RST_TARGET_HUE = 8'd0;
    localparam logic [CFG_W-1:0] RST_TARGET_SAT = 8'd0;
    localparam logic [CFG_W-1:0] RST_SAT_TOL    = 8'd5;

    // commands from controller to datapath
    typedef struct packed {
        logic accept;     // input request taken this cycle
        logic start_div;  // frame end with matches: load the divider
        logic step_div;   // one divider iteration
        logic load_div;   // write the frame result into the output register
    } cbcc_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic need_div;   // current input closes a frame that has matches
    } cbcc_status_t;

endpackage

@@ sv/cbcc_ctrl.sv @@
// cbcc_ctrl: handshake and sequencing state machine for the centroid block
// depends on cbcc_pkg (command and status structs, divider step count)

module cbcc_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    output logic                    out_valid,
    input  logic                    out_stall,
    input  cbcc_pkg::cbcc_status_t  status,
    output cbcc_pkg::cbcc_cmd_t     cmd
);
    import cbcc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_DIVIDE = 3'b010,
        ST_FINISH = 3'b100
    } cbcc_state_t;

    cbcc_state_t         state_reg, state_next;
    logic [STEP_W-1:0]   step_cnt_reg, step_cnt_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_free;
    logic                step_last;

    // output register can take a new request this cycle
    assign out_free  = !out_valid_reg || !out_stall;
    assign step_last = (step_cnt_reg == STEP_W'(DIV_STEPS - 1));

    assign in_stall  = !((state_reg == ST_IDLE) && out_free);
    assign out_valid = out_valid_reg;

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        step_cnt_next  = step_cnt_reg;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && out_free)
                begin
                    cmd.accept = 1'b1;
                    if (status.need_div)
                    begin
                        cmd.start_div = 1'b1;
                        step_cnt_next = '0;
                        state_next    = ST_DIVIDE;
                    end
                end
            end
            ST_DIVIDE:
            begin
                cmd.step_div  = 1'b1;
                step_cnt_next = step_cnt_reg + 1'b1;
                if (step_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.load_div = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output valid: set on load or no-divide accept, cleared when taken
    always_comb
    begin
        if ((cmd.accept && !cmd.start_div) || cmd.load_div)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_cnt_reg  <= step_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    // a frame end with matches always enters the divide sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start_div |=> (state_reg == ST_DIVIDE))
        else $error("divide sequence not started");

    // the divide sequence runs its full count before finishing
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVIDE) && step_last |=> (state_reg == ST_FINISH))
        else $error("divide sequence ended early or late");

    // a stalled result is never dropped
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> out_valid_reg)
        else $error("stalled result lost");

    // a pending frame result holds the finish state while output is busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) && !out_free |=> (state_reg == ST_FINISH))
        else $error("frame result not held");
`endif

endmodule

@@ sv/cbcc_datapath.sv @@
// cbcc_datapath: configuration registers, color match, column accumulators,
// bit-serial divider and output register; depends on cbcc_pkg

module cbcc_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [cbcc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cbcc_pkg::CFG_W-1:0]          cfg_data,
    input  logic [cbcc_pkg::HUE_W-1:0]          pixel_hue,
    input  logic [cbcc_pkg::SAT_W-1:0]          pixel_saturation,
    input  logic                                frame_end,
    output logic                                pixel_match,
    output logic                                frame_done,
    output logic                                color_found,
    output logic signed [cbcc_pkg::AVG_W-1:0]   average_column,
    input  cbcc_pkg::cbcc_cmd_t                 cmd,
    output cbcc_pkg::cbcc_status_t              status
);
    import cbcc_pkg::*;

    // configuration
    logic [CFG_W-1:0]       hue_cfg_reg, sat_cfg_reg, tol_cfg_reg;

    // accumulation state
    logic [COL_W-1:0]       col_reg, col_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next, cnt_final;
    logic [SUM_W-1:0]       sum_reg, sum_next, sum_final;

    // divider state
    logic [CNT_W-1:0]       rem_reg, rem_next;
    logic [SUM_W-1:0]       quo_reg, quo_next;
    logic [CNT_W-1:0]       dvs_reg;
    logic                   neg_reg;
    logic                   hold_match_reg;

    // output register
    logic                   match_out_reg, done_out_reg, found_out_reg;
    logic [AVG_W-1:0]       avg_out_reg;

    // combinational helpers
    logic [SAT_W-1:0]       win_lo, win_hi;
    logic [SAT_W:0]         hi_sum;
    logic                   match;
    logic signed [REL_W-1:0] rel_col;
    logic [SUM_W-1:0]       rel_ext;
    logic [SUM_W-1:0]       mag;
    logic [CNT_W:0]         trial;
    logic                   trial_ge;
    logic [AVG_W-1:0]       avg_sat;

    // configuration writes, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hue_cfg_reg <= RST_TARGET_HUE;
            sat_cfg_reg <= RST_TARGET_SAT;
            tol_cfg_reg <= RST_SAT_TOL;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TARGET_HUE: hue_cfg_reg <= cfg_data;
                CFG_TARGET_SAT: sat_cfg_reg <= cfg_data;
                CFG_SAT_TOL:    tol_cfg_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // saturation window clamped to the byte range, then the match test
    always_comb
    begin
        win_lo = (sat_cfg_reg < tol_cfg_reg) ? '0 : (sat_cfg_reg - tol_cfg_reg);
        hi_sum = {1'b0, sat_cfg_reg} + {1'b0, tol_cfg_reg};
        win_hi = hi_sum[SAT_W] ? SAT_MAX : hi_sum[SAT_W-1:0];
        match  = (pixel_hue == hue_cfg_reg) &&
                 (pixel_saturation >= win_lo) &&
                 (pixel_saturation <= win_hi);
    end

    // centered column and accumulator updates
    always_comb
    begin
        rel_col   = $signed({1'b0, col_reg}) - $signed(REL_W'(HALF_COLUMNS));
        rel_ext   = {{(SUM_W - REL_W){rel_col[REL_W-1]}}, rel_col};
        cnt_final = match ? (cnt_reg + 1'b1) : cnt_reg;
        sum_final = match ? (sum_reg + rel_ext) : sum_reg;
        mag       = sum_final[SUM_W-1] ? (~sum_final + 1'b1) : sum_final;
        status.need_div = frame_end && (cnt_final != '0);

        col_next = col_reg;
        cnt_next = cnt_reg;
        sum_next = sum_reg;
        if (cmd.accept)
        begin
            if (frame_end)
            begin
                col_next = '0;
                cnt_next = '0;
                sum_next = '0;
            end
            else
            begin
                col_next = (col_reg == COL_W'(FRAME_COLUMNS - 1)) ? '0 : (col_reg + 1'b1);
                cnt_next = cnt_final;
                sum_next = sum_final;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            cnt_reg <= '0;
            sum_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            cnt_reg <= cnt_next;
            sum_reg <= sum_next;
        end
    end

    // restoring divider on the magnitude, one quotient bit per step
    always_comb
    begin
        trial    = {rem_reg, quo_reg[SUM_W-1]};
        trial_ge = (trial >= {1'b0, dvs_reg});
        rem_next = trial_ge ? CNT_W'(trial - {1'b0, dvs_reg}) : trial[CNT_W-1:0];
        quo_next = {quo_reg[SUM_W-2:0], trial_ge};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_div)
        begin
            rem_reg        <= '0;
            quo_reg        <= mag;
            dvs_reg        <= cnt_final;
            neg_reg        <= sum_final[SUM_W-1];
            hold_match_reg <= match;
        end
        else if (cmd.step_div)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    // sign restore and saturation of the quotient
    always_comb
    begin
        if (neg_reg)
        begin
            if (quo_reg > SUM_W'(AVG_MIN_MAG))
            begin
                avg_sat = AVG_W'(-AVG_MIN_MAG);
            end
            else
            begin
                avg_sat = ~quo_reg[AVG_W-1:0] + 1'b1;
            end
        end
        else
        begin
            avg_sat = (quo_reg > SUM_W'(AVG_MAX)) ? AVG_W'(AVG_MAX) : quo_reg[AVG_W-1:0];
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.load_div)
        begin
            match_out_reg <= hold_match_reg;
            done_out_reg  <= 1'b1;
            found_out_reg <= 1'b1;
            avg_out_reg   <= avg_sat;
        end
        else if (cmd.accept && !cmd.start_div)
        begin
            match_out_reg <= match;
            done_out_reg  <= frame_end;
            found_out_reg <= 1'b0;
            avg_out_reg   <= '0;
        end
    end

    assign pixel_match    = match_out_reg;
    assign frame_done     = done_out_reg;
    assign color_found    = found_out_reg;
    assign average_column = $signed(avg_out_reg);

`ifndef SYNTHESIS
    // a frame end always returns the column counter and accumulators to zero
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept && frame_end |=> (col_reg == '0) && (cnt_reg == '0) && (sum_reg == '0))
        else $error("accumulators not cleared at frame end");

    // the divider is only loaded with a nonzero divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start_div |=> (dvs_reg != '0))
        else $error("divider loaded with zero count");

    // a found result is always a frame end
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_div |=> frame_done && color_found)
        else $error("frame result flags wrong");
`endif

endmodule

@@ sv/color_blob_column_centroid.sv @@
// color_blob_column_centroid: top level joining controller and datapath
// depends on cbcc_pkg, cbcc_ctrl and cbcc_datapath
//
// Usage: an HSV pixel stream enters on in_valid/in_stall, one request per
// pixel in raster order with frame_end on the last pixel of the frame. Each
// pixel gives exactly one result request on out_valid/out_stall carrying
// pixel_match; the result for the frame end pixel also carries frame_done,
// color_found and the truncated mean matched column relative to the centre.
// A pixel's result is registered in the cycle after acceptance, and a
// new pixel is taken every cycle while the output is drained. A frame end
// pixel with at least one match runs the bit-serial divider, one quotient bit
// per cycle, and its result is loaded through the finish state once the
// output register is free; no pixel is taken during that time. A frame end
// with no match is handled like any pixel.
// When the receiver stalls, the result register holds and in_stall rises
// until it drains. Reset clears the column counter, accumulators, state and
// output valid, and loads the register defaults (tolerance 5). The cfg port
// may be written only while no request is in flight.

module color_blob_column_centroid (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [cbcc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cbcc_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [cbcc_pkg::HUE_W-1:0]          pixel_hue,
    input  logic [cbcc_pkg::SAT_W-1:0]          pixel_saturation,
    input  logic                                frame_end,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                pixel_match,
    output logic                                frame_done,
    output logic                                color_found,
    output logic signed [cbcc_pkg::AVG_W-1:0]   average_column
);
    import cbcc_pkg::*;

    cbcc_cmd_t    cmd;
    cbcc_status_t status;

    // handshake and sequencing
    cbcc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // match, accumulation, divide and result register
    cbcc_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .pixel_hue        (pixel_hue),
        .pixel_saturation (pixel_saturation),
        .frame_end        (frame_end),
        .pixel_match      (pixel_match),
        .frame_done       (frame_done),
        .color_found      (color_found),
        .average_column   (average_column),
        .cmd              (cmd),
        .status           (status)
    );

endmodule
